// ===== sv/reference_pattern_pixel_matcher_assert.svh =====
`ifndef REFERENCE_PATTERN_PIXEL_MATCHER_ASSERT_SVH
`define REFERENCE_PATTERN_PIXEL_MATCHER_ASSERT_SVH

// Same-cycle implication, checked while reset is low.
`define RPPM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rppm same-cycle check failed");

// Next-cycle implication, checked while reset is low.
`define RPPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rppm next-cycle check failed");

`endif

// ===== sv/rppm_pkg.sv =====
package rppm_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned COUNT_W = 23;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned EXP_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = RATIO_W + COUNT_W;

  localparam int unsigned MAX_PIXELS = 4194304;
  localparam logic [COUNT_W-1:0] CNT_LIMIT =
    (MAX_PIXELS < 8388607) ? COUNT_W'(MAX_PIXELS) : COUNT_W'(8388607);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONTRAST    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MASK_PIXELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_RATIO  = 2'd2;

  localparam logic [LEVEL_W-1:0] RST_MIN_CONTRAST    = 8'd16;
  localparam logic [COUNT_W-1:0] RST_MIN_MASK_PIXELS = 23'd1;
  localparam logic [RATIO_W-1:0] RST_REQUIRED_RATIO  = 17'd52429;

  localparam logic [EXP_W-1:0] EXP_BLACK = 2'd0;
  localparam logic [EXP_W-1:0] EXP_WHITE = 2'd1;

  typedef struct packed {
    logic in_mask;
    logic matched;
  } pix_class_t;

endpackage

// ===== sv/rppm_classify.sv =====
module rppm_classify (
  input  logic [rppm_pkg::LEVEL_W-1:0] black_level,
  input  logic [rppm_pkg::LEVEL_W-1:0] white_level,
  input  logic [rppm_pkg::LEVEL_W-1:0] frame_level,
  input  logic [rppm_pkg::EXP_W-1:0]   expected_state,
  input  logic [rppm_pkg::LEVEL_W-1:0] min_contrast,
  output rppm_pkg::pix_class_t         result
);
  import rppm_pkg::*;

  logic                 white_above;
  logic [LEVEL_W-1:0]   diff;
  logic [LEVEL_W:0]     twice;
  logic [LEVEL_W:0]     sum;
  logic                 is_white;

  always_comb begin
    white_above = white_level > black_level;
    diff = white_above ? (white_level - black_level) : (black_level - white_level);
    twice = {frame_level, 1'b0};
    sum = {1'b0, black_level} + {1'b0, white_level};
    is_white = white_above ? (twice > sum) : (twice < sum);
    result.in_mask = diff >= min_contrast;
    result.matched = result.in_mask &&
                     (((expected_state == EXP_WHITE) && is_white) ||
                      ((expected_state == EXP_BLACK) && !is_white));
  end

endmodule

// ===== sv/reference_pattern_pixel_matcher.sv =====
// Channel  | Direction | Handshake          | Payload
// pixel    | in        | in_valid/in_ready  | black/white/frame level, expected, last
// result   | out       | out_valid/out_ready| model_valid, counts, frame_matches
// config   | in        | cfg_we             | cfg_index, cfg_data
// One pixel is taken every cycle while the pipeline is not stalled.
// The last pixel's result passes through the pixel register, the count register
// and the product register to the output register.
// A stalled result holds each stage that has a result waiting behind it.
// Reset is synchronous; it clears the counters and valid flags and resets the config.
module reference_pattern_pixel_matcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rppm_pkg::LEVEL_W-1:0]     black_level,
  input  logic [rppm_pkg::LEVEL_W-1:0]     white_level,
  input  logic [rppm_pkg::LEVEL_W-1:0]     frame_level,
  input  logic [rppm_pkg::EXP_W-1:0]       expected_state,
  input  logic                             last_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             model_valid,
  output logic [rppm_pkg::COUNT_W-1:0]     mask_count,
  output logic [rppm_pkg::COUNT_W-1:0]     matched_count,
  output logic                             frame_matches,
  input  logic                             cfg_we,
  input  logic [rppm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rppm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rppm_pkg::*;

  logic [LEVEL_W-1:0] min_contrast;
  logic [COUNT_W-1:0] min_mask_pixels;
  logic [RATIO_W-1:0] required_ratio_q16;

  logic               a_valid;
  logic [LEVEL_W-1:0] a_black;
  logic [LEVEL_W-1:0] a_white;
  logic [LEVEL_W-1:0] a_frame;
  logic [EXP_W-1:0]   a_expected;
  logic               a_last;

  logic [COUNT_W-1:0] mask_counter;
  logic [COUNT_W-1:0] match_counter;
  logic [COUNT_W-1:0] mask_counter_next;
  logic [COUNT_W-1:0] match_counter_next;

  logic               b_valid;
  logic [COUNT_W-1:0] b_mask;
  logic [COUNT_W-1:0] b_match;

  logic               c_valid;
  logic [COUNT_W-1:0] c_mask;
  logic [COUNT_W-1:0] c_match;
  logic [PROD_W-1:0]  c_rhs;
  logic               c_model_valid;

  logic               a_go;
  logic               b_go;
  logic               c_go;
  logic               b_open;
  logic               c_open;
  logic               out_open;
  pix_class_t         pix;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v < CNT_LIMIT) ? v + COUNT_W'(1) : CNT_LIMIT;
  endfunction

  rppm_classify u_classify (
    .black_level    (a_black),
    .white_level    (a_white),
    .frame_level    (a_frame),
    .expected_state (a_expected),
    .min_contrast   (min_contrast),
    .result         (pix)
  );

  always_comb begin
    out_open = !out_valid || out_ready;
    c_go     = c_valid && out_open;
    c_open   = !c_valid || c_go;
    b_go     = b_valid && c_open;
    b_open   = !b_valid || b_go;
    a_go     = a_valid && (!a_last || b_open);
    in_ready = !a_valid || a_go;
    mask_counter_next  = pix.in_mask ? sat_inc(mask_counter) : mask_counter;
    match_counter_next = pix.matched ? sat_inc(match_counter) : match_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_contrast       <= RST_MIN_CONTRAST;
      min_mask_pixels    <= RST_MIN_MASK_PIXELS;
      required_ratio_q16 <= RST_REQUIRED_RATIO;
      a_valid            <= 1'b0;
      b_valid            <= 1'b0;
      c_valid            <= 1'b0;
      out_valid          <= 1'b0;
      mask_counter       <= '0;
      match_counter      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_CONTRAST:    min_contrast       <= cfg_data[LEVEL_W-1:0];
          CFG_MIN_MASK_PIXELS: min_mask_pixels    <= cfg_data[COUNT_W-1:0];
          CFG_REQUIRED_RATIO:  required_ratio_q16 <= cfg_data[RATIO_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_go) begin
        if (a_last) begin
          mask_counter  <= '0;
          match_counter <= '0;
        end else begin
          mask_counter  <= mask_counter_next;
          match_counter <= match_counter_next;
        end
      end
      if (b_open) begin
        b_valid <= a_go && a_last;
      end
      if (c_open) begin
        c_valid <= b_go;
      end
      if (out_open) begin
        out_valid <= c_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      a_black    <= black_level;
      a_white    <= white_level;
      a_frame    <= frame_level;
      a_expected <= expected_state;
      a_last     <= last_pixel;
    end
    if (b_open) begin
      b_mask  <= mask_counter_next;
      b_match <= match_counter_next;
    end
    if (c_open) begin
      c_mask        <= b_mask;
      c_match       <= b_match;
      c_rhs         <= PROD_W'(required_ratio_q16) * PROD_W'(b_mask);
      c_model_valid <= (min_contrast != '0) && (b_mask != '0) && (b_mask >= min_mask_pixels);
    end
    if (out_open) begin
      model_valid   <= c_model_valid;
      mask_count    <= c_mask;
      matched_count <= c_match;
      frame_matches <= c_model_valid &&
                       ({{(PROD_W-COUNT_W-FRAC_W){1'b0}}, c_match, {FRAC_W{1'b0}}} >= c_rhs);
    end
  end

endmodule

// ===== sv/rppm_checker.sv =====
`include "reference_pattern_pixel_matcher_assert.svh"

module rppm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         model_valid,
  input logic [rppm_pkg::COUNT_W-1:0] mask_count,
  input logic [rppm_pkg::COUNT_W-1:0] matched_count,
  input logic                         frame_matches
);
  import rppm_pkg::*;

  // A frame can only match when its model is valid.
  `RPPM_ASSERT_NOW(a_match_needs_model, clk, rst, out_valid && frame_matches, model_valid)

  // A valid model always has at least one masked pixel.
  `RPPM_ASSERT_NOW(a_model_has_mask, clk, rst, out_valid && model_valid, mask_count != '0)

  // Only masked pixels are counted as matched.
  `RPPM_ASSERT_NOW(a_match_within_mask, clk, rst, out_valid, matched_count <= mask_count)

  // A result that is not taken stays in place.
  `RPPM_ASSERT_NEXT(a_result_holds, clk, rst, !rst && out_valid && !out_ready,
    out_valid && $stable(model_valid) && $stable(mask_count) &&
    $stable(matched_count) && $stable(frame_matches))

endmodule

bind reference_pattern_pixel_matcher rppm_checker u_rppm_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .model_valid   (model_valid),
  .mask_count    (mask_count),
  .matched_count (matched_count),
  .frame_matches (frame_matches)
);

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rppm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASES        = 10;
  localparam int PHASE_PIXELS  = 85;

  localparam logic [EXP_W-1:0] EXP_UNDECIDED = 2'd2;
  localparam logic [EXP_W-1:0] EXP_UNUSED    = 2'd3;

  typedef struct {
    logic               valid;
    logic [COUNT_W-1:0] masked;
    logic [COUNT_W-1:0] hits;
    logic               hit;
  } frame_result_t;

  class matcher_scoreboard;
    logic [LEVEL_W-1:0] contrast_min;
    logic [COUNT_W-1:0] mask_min;
    logic [RATIO_W-1:0] ratio_req;
    logic [COUNT_W-1:0] mask_cnt;
    logic [COUNT_W-1:0] match_cnt;
    frame_result_t      due_q[$];
    int                 errors;

    function new();
      contrast_min = RST_MIN_CONTRAST;
      mask_min     = RST_MIN_MASK_PIXELS;
      ratio_req    = RST_REQUIRED_RATIO;
      mask_cnt     = '0;
      match_cnt    = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_CONTRAST:    contrast_min = data[LEVEL_W-1:0];
        CFG_MIN_MASK_PIXELS: mask_min = data[COUNT_W-1:0];
        CFG_REQUIRED_RATIO:  ratio_req = data[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
      return (v < CNT_LIMIT) ? v + 1'b1 : CNT_LIMIT;
    endfunction

    function void note_pixel(logic [LEVEL_W-1:0] b, logic [LEVEL_W-1:0] w,
                             logic [LEVEL_W-1:0] f, logic [EXP_W-1:0] e, logic last);
      logic [LEVEL_W:0]       diff;
      logic [LEVEL_W:0]       sum;
      logic [LEVEL_W:0]       twice;
      logic                   white;
      logic [PROD_W-1:0]      lhs;
      logic [PROD_W-1:0]      rhs;
      frame_result_t          res;
      diff = (w > b) ? w - b : b - w;
      if (diff >= contrast_min) begin
        sum   = b + w;
        twice = {f, 1'b0};
        white = (w > b) ? (twice > sum) : (twice < sum);
        mask_cnt = bump(mask_cnt);
        if ((e == EXP_WHITE && white) || (e == EXP_BLACK && !white))
          match_cnt = bump(match_cnt);
      end
      if (last) begin
        res.valid   = (contrast_min != 0) && (mask_cnt != 0) && (mask_cnt >= mask_min);
        lhs         = PROD_W'({match_cnt, {FRAC_W{1'b0}}});
        rhs         = PROD_W'(ratio_req) * PROD_W'(mask_cnt);
        res.hit     = res.valid && (lhs >= rhs);
        res.masked  = mask_cnt;
        res.hits    = match_cnt;
        due_q = {due_q, res};
        mask_cnt  = '0;
        match_cnt = '0;
      end
    endfunction

    function void check_result(logic mv, logic [COUNT_W-1:0] mc,
                               logic [COUNT_W-1:0] hc, logic fm);
      frame_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result valid=%0d mask=%0d matched=%0d match=%0d",
                 $time, mv, mc, hc, fm);
        return;
      end
      want = due_q.pop_front();
      if (mv !== want.valid) begin
        errors++;
        $display("%0t: model_valid expected %0d, got %0d", $time, want.valid, mv);
      end
      if (mc !== want.masked) begin
        errors++;
        $display("%0t: mask_count expected %0d, got %0d", $time, want.masked, mc);
      end
      if (hc !== want.hits) begin
        errors++;
        $display("%0t: matched_count expected %0d, got %0d", $time, want.hits, hc);
      end
      if (fm !== want.hit) begin
        errors++;
        $display("%0t: frame_matches expected %0d, got %0d", $time, want.hit, fm);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [LEVEL_W-1:0]    black_level;
  logic [LEVEL_W-1:0]    white_level;
  logic [LEVEL_W-1:0]    frame_level;
  logic [EXP_W-1:0]      expected_state;
  logic                  last_pixel;
  logic                  out_valid;
  logic                  out_ready;
  logic                  model_valid;
  logic [COUNT_W-1:0]    mask_count;
  logic [COUNT_W-1:0]    matched_count;
  logic                  frame_matches;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  matcher_scoreboard sb = new();
  int                cycles = 0;
  bit                steady = 1'b0;
  logic [LEVEL_W-1:0] cur_contrast = RST_MIN_CONTRAST;

  reference_pattern_pixel_matcher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .black_level(black_level), .white_level(white_level), .frame_level(frame_level),
    .expected_state(expected_state), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .model_valid(model_valid), .mask_count(mask_count),
    .matched_count(matched_count), .frame_matches(frame_matches),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(model_valid, mask_count, matched_count, frame_matches);
  end

  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  initial begin
    int run;
    int stall;
    out_ready = 1'b0;
    forever begin
      run = $urandom_range(1, 12);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = gap_cycles();
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  task automatic idle_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid       <= 1'b0;
      black_level    <= LEVEL_W'($urandom);
      white_level    <= LEVEL_W'($urandom);
      frame_level    <= LEVEL_W'($urandom);
      expected_state <= EXP_W'($urandom);
      last_pixel     <= 1'($urandom);
    end
  endtask

  task automatic send_pixel(logic [LEVEL_W-1:0] b, logic [LEVEL_W-1:0] w,
                            logic [LEVEL_W-1:0] f, logic [EXP_W-1:0] e, logic last);
    @(negedge clk);
    in_valid       <= 1'b1;
    black_level    <= b;
    white_level    <= w;
    frame_level    <= f;
    expected_state <= e;
    last_pixel     <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(b, w, f, e, last);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [LEVEL_W-1:0] c, logic [COUNT_W-1:0] m,
                            logic [RATIO_W-1:0] r);
    write_reg(CFG_MIN_CONTRAST, {15'($urandom), c});
    write_reg(CFG_MIN_MASK_PIXELS, m);
    write_reg(CFG_REQUIRED_RATIO, {6'($urandom), r});
    cur_contrast = c;
  endtask

  task automatic make_pixel(output logic [LEVEL_W-1:0] b, output logic [LEVEL_W-1:0] w,
                            output logic [LEVEL_W-1:0] f, output logic [EXP_W-1:0] e);
    int         t;
    logic [8:0] sum;
    logic       white;
    b = LEVEL_W'($urandom);
    w = LEVEL_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        b = 8'd0;
        w = 8'd255;
      end
      1: begin
        b = 8'd255;
        w = 8'd0;
      end
      2: w = b;
      3, 4: begin
        t = int'(cur_contrast) + int'($urandom_range(0, 2)) - 1;
        t = $urandom_range(0, 1) ? int'(b) + t : int'(b) - t;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        w = LEVEL_W'(t);
      end
      default: ;
    endcase
    sum = b + w;
    case ($urandom_range(0, 5))
      0: f = sum[8:1];
      1: f = 8'd0;
      2: f = 8'd255;
      default: f = LEVEL_W'($urandom);
    endcase
    white = (w > b) ? ({f, 1'b0} > sum) : ({f, 1'b0} < sum);
    e = EXP_W'($urandom_range(0, 3));
    if ($urandom_range(0, 3) != 0) e = white ? EXP_WHITE : EXP_BLACK;
  endtask

  function automatic int frame_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 8);
    if (r < 9) return $urandom_range(9, 30);
    return $urandom_range(31, 80);
  endfunction

  task automatic directed_frames();
    send_pixel(8'd0, 8'd255, 8'd255, EXP_WHITE, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, EXP_WHITE, 1'b1);
    send_pixel(8'd0, 8'd254, 8'd127, EXP_BLACK, 1'b1);
    send_pixel(8'd254, 8'd0, 8'd127, EXP_WHITE, 1'b1);
    send_pixel(8'd100, 8'd115, 8'd200, EXP_WHITE, 1'b1);
    send_pixel(8'd100, 8'd116, 8'd200, EXP_WHITE, 1'b0);
    send_pixel(8'd116, 8'd100, 8'd0, EXP_WHITE, 1'b0);
    send_pixel(8'd50, 8'd50, 8'd50, EXP_BLACK, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, EXP_UNDECIDED, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, EXP_UNUSED, 1'b1);
    // Four of five matched sits just below the default ratio of 0.8.
    repeat (4) send_pixel(8'd10, 8'd200, 8'd180, EXP_WHITE, 1'b0);
    send_pixel(8'd10, 8'd200, 8'd180, EXP_BLACK, 1'b1);
    repeat (4) send_pixel(8'd200, 8'd10, 8'd180, EXP_BLACK, 1'b0);
    send_pixel(8'd200, 8'd10, 8'd180, EXP_BLACK, 1'b1);
    drain_results();
    // With zero contrast every pixel is masked but the model is never valid.
    set_config(8'd0, 23'd1, 17'd0);
    send_pixel(8'd7, 8'd7, 8'd7, EXP_BLACK, 1'b1);
    drain_results();
    // A ratio above one can never be reached.
    set_config(8'd1, 23'd0, 17'd131071);
    send_pixel(8'd0, 8'd255, 8'd255, EXP_WHITE, 1'b1);
    drain_results();
  endtask

  initial begin
    logic [LEVEL_W-1:0] b;
    logic [LEVEL_W-1:0] w;
    logic [LEVEL_W-1:0] f;
    logic [EXP_W-1:0]   e;
    int                 len;
    int                 count;
    rst            = 1'b1;
    in_valid       = 1'b0;
    black_level    = '0;
    white_level    = '0;
    frame_level    = '0;
    expected_state = '0;
    last_pixel     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_frames();

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: set_config(8'd1, 23'd0, 17'd0);
        1: set_config(8'd255, 23'd1, 17'd65536);
        2: set_config(8'd0, 23'd1, 17'd52429);
        3: set_config(8'd16, 23'd8388607, 17'd0);
        4: set_config(8'd40, 23'd3, 17'd131071);
        5: set_config(8'd8, 23'd5, 17'd32768);
        default: set_config(LEVEL_W'($urandom_range(0, 255)),
                            COUNT_W'($urandom_range(0, 12)),
                            RATIO_W'($urandom_range(0, 70000)));
      endcase
      steady = (p == 3 || p == 7);
      count = 0;
      while (count < PHASE_PIXELS) begin
        len = frame_length();
        for (int i = 0; i < len; i++) begin
          make_pixel(b, w, f, e);
          send_pixel(b, w, f, e, i == len - 1);
          idle_input(gap_cycles());
          count++;
        end
        if ($urandom_range(0, 19) == 0) drain_results();
      end
    end
    steady = 1'b0;

    drain_results();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rppm_pkg.sv
sv/rppm_classify.sv
sv/reference_pattern_pixel_matcher.sv
sv/rppm_checker.sv
tb/sv/testbench.sv
